// ===== rtl/roman_numeral_encoder_unit_assert.svh =====
// Assertion helpers for the Roman numeral encoder.
// Both macros sample on clk and stay quiet while arst_n is low.
`ifndef ROMAN_NUMERAL_ENCODER_UNIT_ASSERT_SVH
`define ROMAN_NUMERAL_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RNE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RNE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rne_pkg.sv =====
package rne_pkg;

	localparam int ValueW = 12;
	localparam int SymW = 8;
	localparam int DigitW = 4;
	localparam int PlaceW = 2;
	localparam int StepW = 2;
	localparam int RemW = 10;
	localparam int NumPlaces = 4;
	localparam int MaxValue = 3999;
	localparam int Thousand = 1000;
	localparam int Hundred = 100;
	localparam int Ten = 10;

	localparam logic [SymW-1:0] SymNone = 8'h00;
	localparam logic [SymW-1:0] SymI = "I";
	localparam logic [SymW-1:0] SymV = "V";
	localparam logic [SymW-1:0] SymX = "X";
	localparam logic [SymW-1:0] SymL = "L";
	localparam logic [SymW-1:0] SymC = "C";
	localparam logic [SymW-1:0] SymD = "D";
	localparam logic [SymW-1:0] SymM = "M";

	// Symbol role inside one decimal digit
	typedef enum logic [1:0] {
		CODE_END,
		CODE_UNIT,
		CODE_FIVE,
		CODE_NEXT
	} code_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic hund;
		logic tens;
		logic emit;
	} rne_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
		logic char_last;
	} rne_stat_t;

	// Symbol role for a digit at a given character step
	function automatic code_t digit_code(input logic [DigitW-1:0] digit,
			input logic [StepW-1:0] step);
		logic [7:0] row;
		case (digit)
			4'd1: row = {CODE_END, CODE_END, CODE_END, CODE_UNIT};
			4'd2: row = {CODE_END, CODE_END, CODE_UNIT, CODE_UNIT};
			4'd3: row = {CODE_END, CODE_UNIT, CODE_UNIT, CODE_UNIT};
			4'd4: row = {CODE_END, CODE_END, CODE_FIVE, CODE_UNIT};
			4'd5: row = {CODE_END, CODE_END, CODE_END, CODE_FIVE};
			4'd6: row = {CODE_END, CODE_END, CODE_UNIT, CODE_FIVE};
			4'd7: row = {CODE_END, CODE_UNIT, CODE_UNIT, CODE_FIVE};
			4'd8: row = {CODE_UNIT, CODE_UNIT, CODE_UNIT, CODE_FIVE};
			4'd9: row = {CODE_END, CODE_END, CODE_NEXT, CODE_UNIT};
			default: row = {CODE_END, CODE_END, CODE_END, CODE_END};
		endcase
		return code_t'(row[{step, 1'b0} +: 2]);
	endfunction

	// ASCII letter for a symbol role at a decimal place (0 is thousands)
	function automatic logic [SymW-1:0] place_symbol(input logic [PlaceW-1:0] place,
			input code_t code);
		logic [SymW-1:0] sym;
		sym = SymNone;
		case (place)
			2'd0: if (code == CODE_UNIT) sym = SymM;
			2'd1: begin
				case (code)
					CODE_UNIT: sym = SymC;
					CODE_FIVE: sym = SymD;
					CODE_NEXT: sym = SymM;
					default: sym = SymNone;
				endcase
			end
			2'd2: begin
				case (code)
					CODE_UNIT: sym = SymX;
					CODE_FIVE: sym = SymL;
					CODE_NEXT: sym = SymC;
					default: sym = SymNone;
				endcase
			end
			default: begin
				case (code)
					CODE_UNIT: sym = SymI;
					CODE_FIVE: sym = SymV;
					CODE_NEXT: sym = SymX;
					default: sym = SymNone;
				endcase
			end
		endcase
		return sym;
	endfunction

	// Places strictly below the given one in significance
	function automatic logic [NumPlaces-1:0] later_mask(input logic [PlaceW-1:0] place);
		logic [NumPlaces-1:0] m;
		for (int i = 0; i < NumPlaces; i++) begin
			m[i] = (PlaceW'(i) > place);
		end
		return m;
	endfunction

	// Most significant place whose bit is set
	function automatic logic [PlaceW-1:0] first_place(input logic [NumPlaces-1:0] mask);
		logic [PlaceW-1:0] idx;
		idx = '0;
		for (int i = NumPlaces - 1; i >= 0; i--) begin
			if (mask[i]) idx = PlaceW'(i);
		end
		return idx;
	endfunction

endpackage

// ===== rtl/rne_ctrl.sv =====
module rne_ctrl
	import rne_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rne_stat_t stat,
	output rne_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HUND,
		ST_TENS,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Decode commands from the current state
	assign in_ready = (state_q == ST_IDLE);
	always_comb begin
		cmd.load = in_valid && (state_q == ST_IDLE);
		cmd.hund = (state_q == ST_HUND);
		cmd.tens = (state_q == ST_TENS);
		cmd.emit = (state_q == ST_EMIT) && stat.out_free;
	end

	// Advance through extraction, then emit until the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_HUND;
				ST_HUND: state_q <= ST_TENS;
				ST_TENS: state_q <= ST_EMIT;
				ST_EMIT: if (stat.out_free && stat.char_last) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/rne_dp.sv =====
module rne_dp
	import rne_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ValueW-1:0] value,
	input  logic              out_ready,
	input  rne_cmd_t          cmd,
	output rne_stat_t         stat,
	output logic              out_valid,
	output logic [SymW-1:0]   symbol,
	output logic              last,
	output logic              range_error
);

	logic [RemW-1:0]   rem_q;
	logic [DigitW-1:0] dig_q [NumPlaces];
	logic              err_q;
	logic [PlaceW-1:0] place_q;
	logic [StepW-1:0]  step_q;
	logic              out_valid_q;
	logic [SymW-1:0]   symbol_q;
	logic              last_q;
	logic              err_out_q;

	logic [DigitW-1:0] tho_d;
	logic [ValueW-1:0] tho_sub;
	logic [DigitW-1:0] hund_d;
	logic [RemW-1:0]   hund_sub;
	logic [DigitW-1:0] tens_d;
	logic [6:0]        tens_sub;
	logic [DigitW-1:0] ones_d;
	logic [NumPlaces-1:0] start_mask;

	logic [DigitW-1:0]    cur_digit;
	code_t                cur_code;
	code_t                nxt_code;
	logic                 digit_end;
	logic [NumPlaces-1:0] nz_mask;
	logic [NumPlaces-1:0] later;
	logic                 char_last;

	// Thousands digit by compare against the multiples
	always_comb begin
		tho_d = '0;
		tho_sub = '0;
		for (int i = 1; i <= 3; i++) begin
			if (value >= ValueW'(i * Thousand)) begin
				tho_d = DigitW'(i);
				tho_sub = ValueW'(i * Thousand);
			end
		end
	end

	// Hundreds digit from the remainder below one thousand
	always_comb begin
		hund_d = '0;
		hund_sub = '0;
		for (int i = 1; i <= 9; i++) begin
			if (rem_q >= RemW'(i * Hundred)) begin
				hund_d = DigitW'(i);
				hund_sub = RemW'(i * Hundred);
			end
		end
	end

	// Tens and ones digits from the remainder below one hundred
	always_comb begin
		tens_d = '0;
		tens_sub = '0;
		for (int i = 1; i <= 9; i++) begin
			if (rem_q[6:0] >= 7'(i * Ten)) begin
				tens_d = DigitW'(i);
				tens_sub = 7'(i * Ten);
			end
		end
		ones_d = DigitW'(rem_q[6:0] - tens_sub);
		start_mask = {ones_d != '0, tens_d != '0, dig_q[1] != '0, dig_q[0] != '0};
	end

	// Current character and whether it closes the numeral
	always_comb begin
		cur_digit = dig_q[place_q];
		cur_code = digit_code(cur_digit, step_q);
		nxt_code = (step_q == '1) ? CODE_END : digit_code(cur_digit, step_q + 1'b1);
		digit_end = (nxt_code == CODE_END);
		for (int i = 0; i < NumPlaces; i++) begin
			nz_mask[i] = (dig_q[i] != '0);
		end
		later = nz_mask & later_mask(place_q);
		char_last = err_q || (digit_end && (later == '0));
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.char_last = char_last;

	// Digit extraction and character walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dig_q[0] <= tho_d;
			rem_q <= RemW'(value - tho_sub);
			err_q <= (value == '0) || (value > ValueW'(MaxValue));
		end
		if (cmd.hund) begin
			dig_q[1] <= hund_d;
			rem_q <= rem_q - hund_sub;
		end
		if (cmd.tens) begin
			dig_q[2] <= tens_d;
			dig_q[3] <= ones_d;
			place_q <= first_place(start_mask);
			step_q <= '0;
		end
		if (cmd.emit) begin
			if (digit_end) begin
				place_q <= first_place(later);
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			symbol_q <= err_q ? SymNone : place_symbol(place_q, cur_code);
			last_q <= char_last;
			err_out_q <= err_q;
		end
	end

	// Output register valid: set on emit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol = symbol_q;
	assign last = last_q;
	assign range_error = err_out_q;

endmodule

// ===== rtl/roman_numeral_encoder_unit.sv =====
// After the input transfer the controller runs the hundreds and tens extraction
// states, then emits one character per cycle while the output register is free.
// A numeral has 1 to 15 characters, an out-of-range input one blank character;
// a new input is taken only after the final character of the previous one.
// Reset: arst_n clears the controller state and output valid; no memory to clear.
`include "roman_numeral_encoder_unit_assert.svh"

module roman_numeral_encoder_unit
	import rne_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ValueW-1:0] value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SymW-1:0]   symbol,
	output logic              last,
	output logic              range_error
);

	rne_cmd_t  cmd;
	rne_stat_t stat;

	rne_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rne_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.out_ready   (out_ready),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.symbol      (symbol),
		.last        (last),
		.range_error (range_error)
	);

	`RNE_ASSERT_IMP(a_err_single, out_valid && range_error, last && (symbol == SymNone), "error result must be a single blank character")
	`RNE_ASSERT_IMP(a_idle_last, in_ready && out_valid, last, "idle with a pending non-final character")
	`RNE_ASSERT_IMP(a_letter, out_valid && !range_error, (symbol == SymI) || (symbol == SymV) || (symbol == SymX) || (symbol == SymL) || (symbol == SymC) || (symbol == SymD) || (symbol == SymM), "non-error character is not a numeral letter")
	`RNE_ASSERT_NXT(a_busy_after_load, cmd.load, !in_ready && !cmd.emit, "extraction skipped after transfer")

endmodule
